@@ hw/rtl/sawbc_pkg.sv @@
package sawbc_pkg;

    localparam int DEF_WAYS       = 16;
    localparam int DEF_SETS       = 256;
    localparam int DEF_LINE_BYTES = 64;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_FLUSH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ANSWER    = 2'd0,
        KIND_MEM_WRITE = 2'd1,
        KIND_MEM_READ  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RD_LO,
        ST_RD_HI,
        ST_WR_HI,
        ST_WAY_MOD,
        ST_VICTIM,
        ST_WRITEBACK,
        ST_REQUEST,
        ST_FILL,
        ST_FILL_RD,
        ST_FLUSH_RD,
        ST_FLUSH_WR
    } state_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] address;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] mem_address;
        logic [2:0]  mem_byte_count;
        logic [31:0] data;
        logic        was_hit;
        logic        last;
    } rsp_t;

endpackage

@@ hw/rtl/set_assoc_writeback_cache.sv @@
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-------------------------------------------
// item in   | request (req_t)                | taken at clk edge with start=1, busy=0
// result    | result (rsp_t), result_strobe  | valid one cycle, taken at the ending edge
//
// Read hit: lookup, then low and high data word reads; the answer is registered onto
// the result ports after the high word read, with busy high through those steps.
// Write hit: busy through lookup, two data word reads and two word writes.
// Miss: lookup, victim way pick (a reciprocal multiply, quotient then remainder, when
// the set is full), a victim check, a writeback of every word of a dirty victim, a
// request for every word of the line, then one fill item per line word; a read answer
// follows the last fill through a fill read and the low and high data word reads.
// The tag and data memories each have a single read port.
// Reset clears the tag memory one set per cycle; flush reads, then rewrites each set,
// clearing its valid bits. busy is high during both. The receiver cannot stall results.
// SETS and LINE_BYTES are powers of two; WAYS may be any value in range.
module set_assoc_writeback_cache
    import sawbc_pkg::*;
#(
    parameter int WAYS       = DEF_WAYS,
    parameter int SETS       = DEF_SETS,
    parameter int LINE_BYTES = DEF_LINE_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output rsp_t result,
    output logic result_strobe
);

    localparam int OFFW  = $clog2(LINE_BYTES);
    localparam int SETW  = $clog2(SETS);
    localparam int SETI  = (SETW > 0) ? SETW : 1;
    localparam int TAGW  = 32 - OFFW - SETW;
    localparam int WAYI  = $clog2(WAYS);
    localparam int LW    = LINE_BYTES / 4;
    localparam int WORDI = OFFW - 2;
    localparam int LINEI = $clog2(SETS * WAYS);
    localparam int DI    = LINEI + WORDI;
    localparam int MW    = TAGW + 2;
    localparam int SUMW  = ((TAGW > SETW) ? TAGW : SETW) + 1;
    localparam int RSH   = SUMW + WAYI;
    localparam longint unsigned RECIP = ((64'd1 << RSH) + 64'(WAYS) - 64'd1) / 64'(WAYS);
    localparam int RCPW  = SUMW + 1;
    localparam int PRODW = SUMW + RCPW;

    // Tag memory: one row per set, each way holds {valid, dirty, tag}
    logic [MW*WAYS-1:0] meta_mem [SETS];
    logic [MW*WAYS-1:0] meta_q;
    logic               meta_re, meta_we;
    logic [SETI-1:0]    meta_raddr, meta_waddr;
    logic [MW*WAYS-1:0] meta_wdata;

    // Data memory: one word per entry, addressed {line, word}
    logic [31:0]   data_mem [SETS*WAYS*LW];
    logic [31:0]   data_q;
    logic          data_re, data_we;
    logic [DI-1:0] data_raddr, data_waddr;
    logic [31:0]   data_wdata;

    state_t            state_reg, state_next;
    logic [31:0]       addr_reg, addr_next;
    logic [2:0]        cnt_b_reg, cnt_b_next;
    logic [31:0]       wd_reg, wd_next;
    logic              is_write_reg, is_write_next;
    logic              hit_reg, hit_next;
    logic [WAYI-1:0]   way_reg, way_next;
    logic [WORDI-1:0]  word_reg, word_next;
    logic [31:0]       lo_reg, lo_next;
    logic [31:0]       hinew_reg, hinew_next;
    logic [SUMW-1:0]   rem_reg, rem_next;
    logic [SUMW-1:0]   quo_reg, quo_next;
    logic              mod_step_reg, mod_step_next;
    logic [SETI-1:0]   sweep_reg, sweep_next;
    rsp_t              rsp_reg, rsp_next;
    logic              strobe_reg, strobe_next;

    logic              accept;
    logic [SETI-1:0]   cur_set, req_set;
    logic [TAGW-1:0]   cur_tag;
    logic [2:0]        req_n;
    logic [WAYS-1:0]   hit_vec, inv_vec;
    logic [WAYI-1:0]   hit_way, inv_way;
    logic              any_hit, any_inv;
    logic [WAYI-1:0]   rd_way;
    logic [LINEI-1:0]  rd_line;
    logic [WORDI-1:0]  lo_word, hi_word;
    logic [MW-1:0]     vict;
    logic [31:0]       vbase, line_base;
    logic [31:0]       mask32;
    logic [63:0]       win, merged;
    logic [4:0]        sh;
    logic [PRODW-1:0]  prod;
    logic [SUMW-1:0]   mod_rem;
    logic              last_sweep;

    assign accept        = start && !busy;
    assign busy          = !((state_reg == ST_IDLE) || (state_reg == ST_FILL));
    assign result        = rsp_reg;
    assign result_strobe = strobe_reg;

    assign cur_set = (SETW == 0) ? '0 : SETI'(addr_reg >> OFFW);
    assign req_set = (SETW == 0) ? '0 : SETI'(request.address >> OFFW);
    assign cur_tag = TAGW'(addr_reg >> (OFFW + SETW));
    assign last_sweep = (sweep_reg == SETI'(SETS - 1));

    // Clamp byte count to 1..4
    always_comb
    begin
        if (request.byte_count == 3'd0)
            req_n = 3'd1;
        else if (request.byte_count > 3'd4)
            req_n = 3'd4;
        else
            req_n = request.byte_count;
    end

    always_comb
    begin
        unique case (cnt_b_reg)
            3'd1:    mask32 = 32'h0000_00FF;
            3'd2:    mask32 = 32'h0000_FFFF;
            3'd3:    mask32 = 32'h00FF_FFFF;
            default: mask32 = 32'hFFFF_FFFF;
        endcase
    end

    // Way match and first free way of the looked-up set
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        any_hit = 1'b0;
        any_inv = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = meta_q[w*MW + MW-1] && (meta_q[w*MW +: TAGW] == cur_tag);
            inv_vec[w] = !meta_q[w*MW + MW-1];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAYI'(w);
                any_hit = 1'b1;
            end
            if (inv_vec[w])
            begin
                inv_way = WAYI'(w);
                any_inv = 1'b1;
            end
        end
    end

    assign rd_way    = (state_reg == ST_LOOKUP) ? hit_way : way_reg;
    assign rd_line   = LINEI'(32'(cur_set) * WAYS + 32'(rd_way));
    assign lo_word   = addr_reg[OFFW-1:2];
    assign hi_word   = lo_word + WORDI'(1);
    assign vict      = meta_q[way_reg*MW +: MW];
    assign vbase     = ((32'(vict[TAGW-1:0]) << SETW) | 32'(cur_set)) << OFFW;
    assign line_base = addr_reg & ~32'(LINE_BYTES - 1);

    // Two-word window around the access; bytes wrap inside the line
    assign sh     = {addr_reg[1:0], 3'b000};
    assign win    = {data_q, lo_reg};
    assign merged = (win & ~(64'(mask32) << sh)) | (64'(wd_reg & mask32) << sh);

    // (tag + set) mod WAYS by reciprocal multiply: quotient first, remainder next
    assign prod    = PRODW'(rem_reg) * PRODW'(RECIP);
    assign mod_rem = rem_reg - SUMW'(quo_reg * SUMW'(WAYS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (last_sweep)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    unique case (request.opcode)
                        OP_READ, OP_WRITE: state_next = ST_LOOKUP;
                        OP_FLUSH:          state_next = ST_FLUSH_RD;
                        OP_FILL:           state_next = ST_IDLE;
                    endcase
                end
            ST_LOOKUP:
                if (any_hit)
                    state_next = ST_RD_LO;
                else if (any_inv)
                    state_next = ST_VICTIM;
                else
                    state_next = ST_WAY_MOD;
            ST_WAY_MOD:
                if (mod_step_reg)
                    state_next = ST_VICTIM;
            ST_VICTIM:
                state_next = (vict[MW-1] && vict[MW-2]) ? ST_WRITEBACK : ST_REQUEST;
            ST_WRITEBACK:
                if (word_reg == WORDI'(LW - 1))
                    state_next = ST_REQUEST;
            ST_REQUEST:
                if (word_reg == WORDI'(LW - 1))
                    state_next = ST_FILL;
            ST_FILL:
                if (accept && (request.opcode == OP_FILL) && (word_reg == WORDI'(LW - 1)))
                    state_next = is_write_reg ? ST_IDLE : ST_FILL_RD;
            ST_FILL_RD:
                state_next = ST_RD_LO;
            ST_RD_LO:
                state_next = ST_RD_HI;
            ST_RD_HI:
                state_next = is_write_reg ? ST_WR_HI : ST_IDLE;
            ST_WR_HI:
                state_next = ST_IDLE;
            ST_FLUSH_RD:
                state_next = ST_FLUSH_WR;
            ST_FLUSH_WR:
                state_next = last_sweep ? ST_IDLE : ST_FLUSH_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory controls and results
    always_comb
    begin
        meta_re     = 1'b0;
        meta_raddr  = cur_set;
        meta_we     = 1'b0;
        meta_waddr  = cur_set;
        meta_wdata  = meta_q;
        data_re     = 1'b0;
        data_raddr  = {rd_line, lo_word};
        data_we     = 1'b0;
        data_waddr  = {rd_line, lo_word};
        data_wdata  = merged[31:0];
        rsp_next    = '0;
        strobe_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = sweep_reg;
                meta_wdata = '0;
            end
            ST_IDLE:
            begin
                meta_re    = accept;
                meta_raddr = req_set;
            end
            ST_LOOKUP:
            begin
                data_re = any_hit;
                if (!any_hit && is_write_reg)
                begin
                    // send write-miss bytes straight to memory
                    rsp_next.kind           = KIND_MEM_WRITE;
                    rsp_next.mem_address    = addr_reg;
                    rsp_next.mem_byte_count = cnt_b_reg;
                    rsp_next.data           = wd_reg & mask32;
                    strobe_next             = 1'b1;
                end
            end
            ST_VICTIM:
            begin
                data_re    = vict[MW-1] && vict[MW-2];
                data_raddr = {rd_line, WORDI'(0)};
            end
            ST_WRITEBACK:
            begin
                data_re                 = 1'b1;
                data_raddr              = {rd_line, word_reg + WORDI'(1)};
                rsp_next.kind           = KIND_MEM_WRITE;
                rsp_next.mem_address    = vbase | (32'(word_reg) << 2);
                rsp_next.mem_byte_count = 3'd4;
                rsp_next.data           = data_q;
                strobe_next             = 1'b1;
            end
            ST_REQUEST:
            begin
                if (word_reg == '0)
                begin
                    // allocate: valid, clean, new tag
                    meta_we = 1'b1;
                    meta_wdata[way_reg*MW +: MW] = {1'b1, 1'b0, cur_tag};
                end
                rsp_next.kind           = KIND_MEM_READ;
                rsp_next.mem_address    = line_base | (32'(word_reg) << 2);
                rsp_next.mem_byte_count = 3'd4;
                rsp_next.last           = (word_reg == WORDI'(LW - 1));
                strobe_next             = 1'b1;
            end
            ST_FILL:
            begin
                data_we    = accept && (request.opcode == OP_FILL);
                data_waddr = {rd_line, word_reg};
                data_wdata = request.write_data;
            end
            ST_FILL_RD:
                data_re = 1'b1;
            ST_RD_LO:
            begin
                data_re    = 1'b1;
                data_raddr = {rd_line, hi_word};
            end
            ST_RD_HI:
            begin
                if (is_write_reg)
                    data_we = 1'b1;
                else
                begin
                    rsp_next.kind           = KIND_ANSWER;
                    rsp_next.mem_address    = addr_reg;
                    rsp_next.mem_byte_count = cnt_b_reg;
                    rsp_next.data           = 32'(win >> sh) & mask32;
                    rsp_next.was_hit        = hit_reg;
                    rsp_next.last           = 1'b1;
                    strobe_next             = 1'b1;
                end
            end
            ST_WR_HI:
            begin
                data_we    = 1'b1;
                data_waddr = {rd_line, hi_word};
                data_wdata = hinew_reg;
                meta_we    = 1'b1;
                meta_wdata[way_reg*MW + MW-2] = 1'b1;
            end
            ST_FLUSH_RD:
            begin
                meta_re    = 1'b1;
                meta_raddr = sweep_reg;
            end
            ST_FLUSH_WR:
            begin
                meta_we    = 1'b1;
                meta_waddr = sweep_reg;
                for (int w = 0; w < WAYS; w++)
                    meta_wdata[w*MW + MW-1] = 1'b0;
            end
            default:
            begin
                meta_re = 1'b0;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        addr_next     = addr_reg;
        cnt_b_next    = cnt_b_reg;
        wd_next       = wd_reg;
        is_write_next = is_write_reg;
        hit_next      = hit_reg;
        way_next      = way_reg;
        word_next     = word_reg;
        lo_next       = lo_reg;
        hinew_next    = hinew_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        mod_step_next = mod_step_reg;
        sweep_next    = sweep_reg;
        unique case (state_reg)
            ST_CLEAR:
                sweep_next = sweep_reg + SETI'(1);
            ST_IDLE:
                if (accept)
                begin
                    addr_next     = request.address;
                    cnt_b_next    = req_n;
                    wd_next       = request.write_data;
                    is_write_next = (request.opcode == OP_WRITE);
                    sweep_next    = '0;
                end
            ST_LOOKUP:
            begin
                hit_next  = any_hit;
                word_next = '0;
                if (any_hit)
                    way_next = hit_way;
                else if (any_inv)
                    way_next = inv_way;
                else
                begin
                    rem_next      = SUMW'(cur_tag) + SUMW'(cur_set);
                    mod_step_next = 1'b0;
                end
            end
            ST_WAY_MOD:
            begin
                if (!mod_step_reg)
                begin
                    quo_next      = SUMW'(prod >> RSH);
                    mod_step_next = 1'b1;
                end
                else
                    way_next = WAYI'(mod_rem);
            end
            ST_WRITEBACK, ST_REQUEST:
                word_next = word_reg + WORDI'(1);
            ST_FILL:
                if (accept && (request.opcode == OP_FILL))
                    word_next = word_reg + WORDI'(1);
            ST_RD_LO:
                lo_next = data_q;
            ST_RD_HI:
                hinew_next = merged[63:32];
            ST_FLUSH_WR:
                sweep_next = sweep_reg + SETI'(1);
            default:
                hit_next = hit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        if (meta_re)
            meta_q <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
            data_mem[data_waddr] <= data_wdata;
        if (data_re)
            data_q <= data_mem[data_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            word_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            word_reg   <= word_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        cnt_b_reg    <= cnt_b_next;
        wd_reg       <= wd_next;
        is_write_reg <= is_write_next;
        hit_reg      <= hit_next;
        way_reg      <= way_next;
        lo_reg       <= lo_next;
        hinew_reg    <= hinew_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        mod_step_reg <= mod_step_next;
        rsp_reg      <= rsp_next;
    end

endmodule
